### rtl/assert_macros.svh
// Assertion macros for the RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/lmu_pkg.sv
// Types and constants of the landmark map update block.
package lmu_pkg;
    localparam int MAP_DEPTH = 256;
    localparam int FRAME_DEPTH = 32;
    localparam int MAP_AW = $clog2(MAP_DEPTH);
    localparam int MAP_CW = $clog2(MAP_DEPTH + 1);
    localparam int FB_AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FB_CW = $clog2(FRAME_DEPTH + 1);

    localparam logic [1:0] CFG_GROUND = 2'd0;
    localparam logic [1:0] CFG_OFS_X = 2'd1;
    localparam logic [1:0] CFG_OFS_Y = 2'd2;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_POSE = 1'b1;

    typedef struct packed {
        logic [7:0] landmark_id;
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
        logic signed [31:0] altitude;
        logic frame_last;
    } request_t;

    typedef struct packed {
        logic result_kind;
        logic [7:0] entry_id;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] global_z;
        logic map_full_drop;
        logic run_last;
    } result_t;

    typedef struct packed {
        logic [7:0] id;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } obs_t;

    // a - b + c formed exactly, saturated to the signed 32-bit range
    function automatic logic signed [31:0] sat_sub_add(input logic signed [31:0] a,
        input logic signed [31:0] b, input logic signed [31:0] c);
        logic signed [33:0] s;
        s = 34'(a) - 34'(b) + 34'(c);
        if (s > 34'sd2147483647) return 32'sh7fffffff;
        else if (s < -34'sd2147483648) return 32'sh80000000;
        else return s[31:0];
    endfunction
endpackage

### rtl/lmu_map_mem.sv
// Map storage: ids and global positions, one synchronous port each way.
module lmu_map_mem (
    input  logic clk,
    input  logic we,
    input  logic [lmu_pkg::MAP_AW-1:0] waddr,
    input  lmu_pkg::obs_t wdata,
    input  logic [lmu_pkg::MAP_AW-1:0] raddr,
    output lmu_pkg::obs_t rdata
);
    lmu_pkg::obs_t mem [lmu_pkg::MAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/lmu_frame_mem.sv
// Frame buffer of observations with ids not yet in the map.
module lmu_frame_mem (
    input  logic clk,
    input  logic we,
    input  logic [lmu_pkg::FB_AW-1:0] waddr,
    input  lmu_pkg::obs_t wdata,
    input  logic [lmu_pkg::FB_AW-1:0] raddr,
    output lmu_pkg::obs_t rdata
);
    lmu_pkg::obs_t mem [lmu_pkg::FRAME_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/landmark_map_update_top.sv
// Top level of the landmark map update block.
// Usage:
//   Write the ground id and the camera x and y offsets over the cfg
//   channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while idle.
//   Issue one observation per request with start while busy is low.
//   Each request searches the map from the newest entry down, one map
//   read per cycle through the single read port of the map memory.
//   On a request with frame_last, new entries are appended newest first,
//   each by a buffer read, then an add and a write; then the pose follows.
//   Results appear on result with result_valid high for one cycle; the
//   receiver cannot stall, so results are never held back.
//   A frame with no reference gives no results.
//   Reset clears the map to the single ground entry at the origin and
//   clears all frame state; the map memory needs no clearing pass,
//   since entries beyond map_count are never read.
module landmark_map_update_top (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  lmu_pkg::request_t request,
    output logic result_valid,
    output lmu_pkg::result_t result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    `include "assert_macros.svh"

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SRCH   = 7'b0000010,
        S_CHK    = 7'b0000100,
        S_RDREF  = 7'b0001000,
        S_RDFB   = 7'b0010000,
        S_APP    = 7'b0100000,
        S_POSE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] ground_reg;
    logic signed [31:0] ofs_x_reg, ofs_y_reg;

    lmu_pkg::request_t req_reg;
    logic [lmu_pkg::MAP_CW-1:0] map_count_reg, frame_map_count_reg;
    logic [lmu_pkg::MAP_CW-1:0] idx_reg;
    logic [lmu_pkg::FB_CW-1:0] frame_count_reg, k_reg;
    logic [lmu_pkg::MAP_AW-1:0] ref_idx_reg;
    logic signed [31:0] ref_lx_reg, ref_ly_reg, gx_reg, gy_reg;
    logic ref_valid_reg, ground_seen_reg, hit_reg, gfirst_reg;
    logic [lmu_pkg::MAP_AW-1:0] hit_idx_reg;
    logic [lmu_pkg::MAP_AW-1:0] rd_idx_reg;
    logic rd_pend_reg;
    logic out_valid_reg;
    lmu_pkg::result_t out_reg;

    logic map_we, fb_we;
    logic [lmu_pkg::MAP_AW-1:0] map_waddr, map_raddr;
    lmu_pkg::obs_t map_wdata, map_rdata, fb_rdata, fb_wdata;
    logic [lmu_pkg::FB_AW-1:0] fb_waddr, fb_raddr;
    logic [7:0] map_id;
    logic signed [31:0] px, py;

    // gx/gy for the pose, taken from the map read when no entries were appended
    logic signed [31:0] gx_r, gy_r;
    logic ref_loaded_reg;

    lmu_map_mem u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );
    lmu_frame_mem u_fb (
        .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = out_valid_reg;
    assign result = out_reg;

    // entry 0 always reads as ground id 0 at the origin
    assign map_id = (rd_idx_reg == '0) ? 8'd0 : map_rdata.id;

    always_comb
    begin
        map_raddr = '0;
        unique case (state_reg)
            S_SRCH: map_raddr = lmu_pkg::MAP_AW'(idx_reg - 1'b1);
            S_RDREF: map_raddr = ref_idx_reg;
            default: map_raddr = '0;
        endcase
    end

    assign fb_raddr = lmu_pkg::FB_AW'(k_reg - 1'b1);
    assign fb_waddr = lmu_pkg::FB_AW'(frame_count_reg);
    assign fb_wdata = '{id: req_reg.landmark_id, x: req_reg.local_x, y: req_reg.local_y};
    assign fb_we = (state_reg == S_CHK) && !hit_reg
        && (frame_count_reg < lmu_pkg::FB_CW'(lmu_pkg::FRAME_DEPTH));

    assign px = lmu_pkg::sat_sub_add(fb_rdata.x, ref_lx_reg, gx_reg);
    assign py = lmu_pkg::sat_sub_add(fb_rdata.y, ref_ly_reg, gy_reg);
    assign map_we = (state_reg == S_APP)
        && (map_count_reg < lmu_pkg::MAP_CW'(lmu_pkg::MAP_DEPTH));
    assign map_waddr = lmu_pkg::MAP_AW'(map_count_reg);
    assign map_wdata = '{id: fb_rdata.id, x: px, y: py};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_SRCH;
            S_SRCH: if (hit_reg || (idx_reg == '0 && !rd_pend_reg)) state_next = S_CHK;
            S_CHK:
                if (!req_reg.frame_last) state_next = S_IDLE;
                else if (!(ref_valid_reg || gfirst_reg || hit_reg)) state_next = S_IDLE;
                else state_next = S_RDREF;
            S_RDREF: state_next = (k_reg != '0) ? S_RDFB : S_POSE;
            S_RDFB: state_next = S_APP;
            S_APP: state_next = (k_reg != '0) ? S_RDFB : S_POSE;
            S_POSE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ground_reg <= '0;
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
            map_count_reg <= lmu_pkg::MAP_CW'(1);
            frame_map_count_reg <= lmu_pkg::MAP_CW'(1);
            frame_count_reg <= '0;
            ref_valid_reg <= 1'b0;
            ground_seen_reg <= 1'b0;
            ref_idx_reg <= '0;
            ref_lx_reg <= '0;
            ref_ly_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            gfirst_reg <= 1'b0;
            idx_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= (state_reg == S_APP) || (state_reg == S_POSE);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lmu_pkg::CFG_GROUND: ground_reg <= cfg_data[7:0];
                    lmu_pkg::CFG_OFS_X: ofs_x_reg <= cfg_data;
                    lmu_pkg::CFG_OFS_Y: ofs_y_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        idx_reg <= frame_map_count_reg;
                        rd_pend_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        gfirst_reg <= !ground_seen_reg
                            && (request.landmark_id == ground_reg);
                    end
                S_SRCH:
                begin
                    if (rd_pend_reg && map_id == req_reg.landmark_id)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        rd_pend_reg <= 1'b0;
                    end
                    else if (idx_reg != '0)
                    begin
                        rd_idx_reg <= map_raddr;
                        idx_reg <= idx_reg - 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                end
                S_CHK:
                begin
                    if (gfirst_reg)
                    begin
                        ground_seen_reg <= 1'b1;
                        ref_valid_reg <= 1'b1;
                        ref_idx_reg <= '0;
                        ref_lx_reg <= req_reg.local_x;
                        ref_ly_reg <= req_reg.local_y;
                    end
                    else if (hit_reg && !ground_seen_reg)
                    begin
                        ref_valid_reg <= 1'b1;
                        ref_idx_reg <= hit_idx_reg;
                        ref_lx_reg <= req_reg.local_x;
                        ref_ly_reg <= req_reg.local_y;
                    end
                    if (req_reg.frame_last && state_next == S_IDLE)
                    begin
                        frame_count_reg <= '0;
                        ref_valid_reg <= 1'b0;
                        ground_seen_reg <= 1'b0;
                        ref_idx_reg <= '0;
                    end
                    else if (fb_we)
                    begin
                        frame_count_reg <= frame_count_reg + 1'b1;
                        k_reg <= frame_count_reg + 1'b1;
                    end
                    else
                    begin
                        k_reg <= frame_count_reg;
                    end
                end
                S_RDREF:
                begin
                    rd_idx_reg <= ref_idx_reg;
                end
                S_RDFB:
                begin
                    if (rd_idx_reg == ref_idx_reg)
                    begin
                        gx_reg <= (ref_idx_reg == '0) ? 32'sd0 : map_rdata.x;
                        gy_reg <= (ref_idx_reg == '0) ? 32'sd0 : map_rdata.y;
                        rd_idx_reg <= ~ref_idx_reg;
                    end
                    k_reg <= k_reg - 1'b1;
                end
                S_APP:
                begin
                    out_reg <= '{result_kind: lmu_pkg::KIND_ENTRY, entry_id: fb_rdata.id,
                        world_x: px, world_y: py, global_z: 32'sd0,
                        map_full_drop: !map_we, run_last: 1'b0};
                    if (map_we)
                    begin
                        map_count_reg <= map_count_reg + 1'b1;
                    end
                end
                S_POSE:
                begin
                    out_reg <= '{result_kind: lmu_pkg::KIND_POSE, entry_id: 8'd0,
                        world_x: lmu_pkg::sat_sub_add(ofs_x_reg, ref_lx_reg, gx_r),
                        world_y: lmu_pkg::sat_sub_add(ofs_y_reg, ref_ly_reg, gy_r),
                        global_z: req_reg.altitude, map_full_drop: 1'b0,
                        run_last: 1'b1};
                    frame_map_count_reg <= map_count_reg;
                    frame_count_reg <= '0;
                    ref_valid_reg <= 1'b0;
                    ground_seen_reg <= 1'b0;
                    ref_idx_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_loaded_reg <= 1'b0;
        end
        else
        begin
            ref_loaded_reg <= (state_reg == S_RDREF);
        end
    end
    assign gx_r = (ref_idx_reg == '0) ? 32'sd0 : (ref_loaded_reg ? map_rdata.x : gx_reg);
    assign gy_r = (ref_idx_reg == '0) ? 32'sd0 : (ref_loaded_reg ? map_rdata.y : gy_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= request;
        end
    end

    `ASSERT_IMPL(a_pose_last, clk, rst_n,
        (out_valid_reg && out_reg.run_last) |-> (out_reg.result_kind == lmu_pkg::KIND_POSE))
    `ASSERT_NEVER(a_map_over, clk, rst_n,
        map_count_reg > lmu_pkg::MAP_CW'(lmu_pkg::MAP_DEPTH))
    `ASSERT_NEVER(a_fb_over, clk, rst_n,
        frame_count_reg > lmu_pkg::FB_CW'(lmu_pkg::FRAME_DEPTH))
    `ASSERT_IMPL(a_out_busy, clk, rst_n,
        (state_reg == S_APP) |=> out_valid_reg)
endmodule
